// ===== src/trapezoid_velocity_planner_1d_assert.svh =====
// Assertion macros for the velocity planner RTL.
`ifndef TRAPEZOID_VELOCITY_PLANNER_1D_ASSERT_SVH
`define TRAPEZOID_VELOCITY_PLANNER_1D_ASSERT_SVH

`define TVP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`define TVP_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);

`endif

// ===== src/tvp_pkg.sv =====
// Shared types and constants for the trapezoidal velocity planner.
package tvp_pkg;

    localparam int CfgW   = 31;
    localparam int PosW   = 32;
    localparam int LenW   = 33;
    localparam int SpanW  = 34;
    localparam int SqW    = 62;
    localparam int ProdW  = 64;
    localparam int RootW  = 32;
    localparam int IdxW   = 4;
    localparam int Stages = 32;

    localparam logic [IdxW-1:0] REG_MAX_ACC  = 4'd0;
    localparam logic [IdxW-1:0] REG_MAX_DEC  = 4'd1;
    localparam logic [IdxW-1:0] REG_TOP      = 4'd2;
    localparam logic [IdxW-1:0] REG_START_V  = 4'd3;
    localparam logic [IdxW-1:0] REG_END_V    = 4'd4;
    localparam logic [IdxW-1:0] REG_START_P  = 4'd5;
    localparam logic [IdxW-1:0] REG_TARGET_P = 4'd6;
    localparam logic [IdxW-1:0] REG_DEADZONE = 4'd7;

    localparam logic [1:0] SIGN_ZERO = 2'b00;
    localparam logic [1:0] SIGN_POS  = 2'b01;
    localparam logic [1:0] SIGN_NEG  = 2'b11;

    localparam logic [1:0] PH_ACCEL  = 2'd0;
    localparam logic [1:0] PH_CRUISE = 2'd1;
    localparam logic [1:0] PH_DECEL  = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    typedef struct packed {
        logic [CfgW-1:0]         max_acc;
        logic [CfgW-1:0]         max_dec;
        logic [CfgW-1:0]         top;
        logic [CfgW-1:0]         end_speed;
        logic signed [PosW-1:0]  start_pos;
        logic signed [PosW-1:0]  target_pos;
        logic [CfgW-1:0]         deadzone;
        logic [LenW-1:0]         len;
        logic [SpanW-1:0]        accel_span;
        logic [SpanW-1:0]        decel_span;
        logic [1:0]              sign;
        logic [SqW-1:0]          v02;
        logic [SqW-1:0]          vf2;
        logic                    busy;
    } t_plan;

    typedef struct packed {
        logic            direct;
        logic [CfgW-1:0] dspeed;
        logic [1:0]      sign;
        logic [1:0]      phase;
    } t_side;

endpackage

// ===== src/tvp_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
module tvp_div
    import tvp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [ProdW-1:0]   i_num,
    input  logic [SpanW-1:0]   i_den,
    output logic               o_done,
    output logic [ProdW-1:0]   o_quot
);

    logic               r_busy;
    logic               r_done;
    logic [5:0]         r_cnt;
    logic [ProdW-1:0]   r_num;
    logic [ProdW-1:0]   r_quot;
    logic [SpanW-1:0]   r_rem;
    logic [SpanW-1:0]   r_den;
    logic [SpanW:0]     rem_sh;
    logic               ge;

    assign rem_sh = {r_rem, r_num[ProdW-1]};
    assign ge     = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd63;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num  <= {r_num[ProdW-2:0], 1'b0};
            r_rem  <= ge ? SpanW'(rem_sh - {1'b0, r_den}) : rem_sh[SpanW-1:0];
            r_quot <= {r_quot[ProdW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== src/tvp_plan.sv =====
// Configuration registers and the sequencer that replans the move.
module tvp_plan
    import tvp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [IdxW-1:0]    i_cfg_index,
    input  logic [PosW-1:0]    i_cfg_data,
    output t_plan              o_plan
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_VT   = 5'd1;
    localparam logic [4:0] S_V0   = 5'd2;
    localparam logic [4:0] S_VF   = 5'd3;
    localparam logic [4:0] S_FA   = 5'd4;
    localparam logic [4:0] S_FAW  = 5'd5;
    localparam logic [4:0] S_FD   = 5'd6;
    localparam logic [4:0] S_FDW  = 5'd7;
    localparam logic [4:0] S_CMP  = 5'd8;
    localparam logic [4:0] S_TW   = 5'd9;
    localparam logic [4:0] S_ML1  = 5'd10;
    localparam logic [4:0] S_D1   = 5'd11;
    localparam logic [4:0] S_D1W  = 5'd12;
    localparam logic [4:0] S_ML2  = 5'd13;
    localparam logic [4:0] S_D2   = 5'd14;
    localparam logic [4:0] S_D2W  = 5'd15;
    localparam logic [4:0] S_FIN  = 5'd16;

    localparam logic [CfgW-1:0] RST_LIMIT = 31'd65536;

    logic [4:0]              r_state;
    logic [CfgW-1:0]         r_max_acc, r_max_dec, r_top, r_start_v, r_end_v, r_deadzone;
    logic signed [PosW-1:0]  r_start_p, r_target_p;
    logic [LenW-1:0]         r_len;
    logic [1:0]              r_sign;
    logic [SqW-1:0]          r_vt2, r_v02, r_vf2;
    logic [ProdW-1:0]        r_facc, r_fdec, r_t, r_q1, r_q2, r_prod;
    logic [SpanW-1:0]        r_accel, r_decel;

    logic [CfgW-1:0]         a_eff, d_eff;
    logic [PosW-1:0]         s_sum;
    logic signed [LenW-1:0]  diff;
    logic [CfgW-1:0]         mul_x;
    logic [LenW-1:0]         mul_y;
    logic [ProdW-1:0]        mul_p;
    logic                    div_start, div_done;
    logic [ProdW-1:0]        div_num, div_quot;
    logic [SpanW-1:0]        div_den;
    logic                    t_neg;
    logic [SqW-1:0]          mag;
    logic [ProdW:0]          full_sum;
    logic signed [ProdW+1:0] t_s, acc_v, dec_v;

    assign a_eff = (r_max_acc == '0) ? CfgW'(1) : r_max_acc;
    assign d_eff = (r_max_dec == '0) ? CfgW'(1) : r_max_dec;
    assign s_sum = {1'b0, a_eff} + {1'b0, d_eff};
    assign diff  = {r_target_p[PosW-1], r_target_p} - {r_start_p[PosW-1], r_start_p};
    assign t_neg = r_vf2 < r_v02;
    assign mag   = t_neg ? r_v02 - r_vf2 : r_vf2 - r_v02;
    assign full_sum = {1'b0, r_facc} + {1'b0, r_fdec};
    assign t_s   = t_neg ? -$signed({2'b00, r_t}) : $signed({2'b00, r_t});
    assign acc_v = $signed({2'b00, r_q1}) + t_s;
    assign dec_v = $signed({2'b00, r_q2}) - t_s;

    always_comb begin
        case (r_state)
            S_VT:    begin mul_x = r_top;     mul_y = LenW'(r_top);     end
            S_V0:    begin mul_x = r_start_v; mul_y = LenW'(r_start_v); end
            S_VF:    begin mul_x = r_end_v;   mul_y = LenW'(r_end_v);   end
            S_ML1:   begin mul_x = d_eff;     mul_y = r_len;            end
            default: begin mul_x = a_eff;     mul_y = r_len;            end
        endcase
    end
    assign mul_p = {33'd0, mul_x} * {31'd0, mul_y};

    always_comb begin
        div_start = 1'b0;
        div_num   = r_prod;
        div_den   = SpanW'(s_sum);
        case (r_state)
            S_FA: begin
                div_start = r_top > r_start_v;
                div_num   = ProdW'(r_vt2 - r_v02);
                div_den   = SpanW'({a_eff, 1'b0});
            end
            S_FD: begin
                div_start = r_top > r_end_v;
                div_num   = ProdW'(r_vt2 - r_vf2);
                div_den   = SpanW'({d_eff, 1'b0});
            end
            S_CMP: begin
                div_start = full_sum > {32'd0, r_len};
                div_num   = ProdW'(mag);
                div_den   = SpanW'({s_sum, 1'b0});
            end
            S_D1, S_D2: begin
                div_start = 1'b1;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    tvp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_VT;
            r_max_acc  <= RST_LIMIT;
            r_max_dec  <= RST_LIMIT;
            r_top      <= RST_LIMIT;
            r_start_v  <= '0;
            r_end_v    <= '0;
            r_start_p  <= '0;
            r_target_p <= '0;
            r_deadzone <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid && i_cfg_index <= REG_DEADZONE) begin
                        r_state <= S_VT;
                        case (i_cfg_index)
                            REG_MAX_ACC:  r_max_acc  <= i_cfg_data[CfgW-1:0];
                            REG_MAX_DEC:  r_max_dec  <= i_cfg_data[CfgW-1:0];
                            REG_TOP:      r_top      <= i_cfg_data[CfgW-1:0];
                            REG_START_V:  r_start_v  <= i_cfg_data[CfgW-1:0];
                            REG_END_V:    r_end_v    <= i_cfg_data[CfgW-1:0];
                            REG_START_P:  r_start_p  <= i_cfg_data;
                            REG_TARGET_P: r_target_p <= i_cfg_data;
                            default:      r_deadzone <= i_cfg_data[CfgW-1:0];
                        endcase
                    end
                end
                S_VT:  r_state <= S_V0;
                S_V0:  r_state <= S_VF;
                S_VF:  r_state <= S_FA;
                S_FA:  r_state <= (r_top > r_start_v) ? S_FAW : S_FD;
                S_FAW: if (div_done) r_state <= S_FD;
                S_FD:  r_state <= (r_top > r_end_v) ? S_FDW : S_CMP;
                S_FDW: if (div_done) r_state <= S_CMP;
                S_CMP: r_state <= (full_sum > {32'd0, r_len}) ? S_TW : S_IDLE;
                S_TW:  if (div_done) r_state <= S_ML1;
                S_ML1: r_state <= S_D1;
                S_D1:  r_state <= S_D1W;
                S_D1W: if (div_done) r_state <= S_ML2;
                S_ML2: r_state <= S_D2;
                S_D2:  r_state <= S_D2W;
                S_D2W: if (div_done) r_state <= S_FIN;
                S_FIN: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_VT: begin
                r_vt2  <= mul_p[SqW-1:0];
                r_len  <= diff[LenW-1] ? LenW'(-diff) : diff;
                r_sign <= diff[LenW-1] ? SIGN_NEG : ((diff == '0) ? SIGN_ZERO : SIGN_POS);
            end
            S_V0:  r_v02 <= mul_p[SqW-1:0];
            S_VF:  r_vf2 <= mul_p[SqW-1:0];
            S_FA:  if (!(r_top > r_start_v)) r_facc <= '0;
            S_FAW: if (div_done) r_facc <= div_quot;
            S_FD:  if (!(r_top > r_end_v)) r_fdec <= '0;
            S_FDW: if (div_done) r_fdec <= div_quot;
            S_CMP: begin
                if (!(full_sum > {32'd0, r_len})) begin
                    r_accel <= r_facc[SpanW-1:0];
                    r_decel <= r_fdec[SpanW-1:0];
                end
            end
            S_TW:  if (div_done) r_t <= div_quot;
            S_ML1: r_prod <= mul_p;
            S_D1W: if (div_done) r_q1 <= div_quot;
            S_ML2: r_prod <= mul_p;
            S_D2W: if (div_done) r_q2 <= div_quot;
            S_FIN: begin
                if (acc_v[ProdW+1])
                    r_accel <= '0;
                else if (acc_v > $signed({33'd0, r_len}))
                    r_accel <= SpanW'(r_len);
                else
                    r_accel <= acc_v[SpanW-1:0];
                if (dec_v[ProdW+1])
                    r_decel <= '0;
                else if (dec_v > $signed({33'd0, r_len}))
                    r_decel <= SpanW'(r_len);
                else
                    r_decel <= dec_v[SpanW-1:0];
            end
            default: begin
                r_prod <= r_prod;
            end
        endcase
    end

    assign o_cfg_ready = (r_state == S_IDLE);

    always_comb begin
        o_plan.max_acc    = r_max_acc;
        o_plan.max_dec    = r_max_dec;
        o_plan.top        = r_top;
        o_plan.end_speed  = r_end_v;
        o_plan.start_pos  = r_start_p;
        o_plan.target_pos = r_target_p;
        o_plan.deadzone   = r_deadzone;
        o_plan.len        = r_len;
        o_plan.accel_span = r_accel;
        o_plan.decel_span = r_decel;
        o_plan.sign       = r_sign;
        o_plan.v02        = r_v02;
        o_plan.vf2        = r_vf2;
        o_plan.busy       = (r_state != S_IDLE);
    end

endmodule

// ===== src/tvp_isqrt.sv =====
// Pipelined floor square root, one result bit per stage.
module tvp_isqrt
    import tvp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [ProdW-1:0]   i_rad,
    input  t_side              i_side,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [RootW-1:0]   o_root,
    output t_side              o_side
);

    localparam int RemW = RootW + 3;

    logic               r_v    [0:Stages-1];
    logic [RemW-1:0]    r_rem  [0:Stages-1];
    logic [RootW-1:0]   r_root [0:Stages-1];
    logic [ProdW-1:0]   r_x    [0:Stages-1];
    t_side              r_side [0:Stages-1];
    logic               adv    [0:Stages];

    assign adv[Stages] = i_ready;

    for (genvar k = 0; k < Stages; k++) begin : g_stage
        logic             in_v;
        logic [RemW-1:0]  in_rem;
        logic [RootW-1:0] in_root;
        logic [ProdW-1:0] in_x;
        t_side            in_side;
        logic [RemW-1:0]  rem_sh, trial;
        logic             ge;

        if (k == 0) begin : g_first
            assign in_v    = i_valid;
            assign in_rem  = '0;
            assign in_root = '0;
            assign in_x    = i_rad;
            assign in_side = i_side;
        end else begin : g_next
            assign in_v    = r_v[k-1];
            assign in_rem  = r_rem[k-1];
            assign in_root = r_root[k-1];
            assign in_x    = r_x[k-1];
            assign in_side = r_side[k-1];
        end

        assign rem_sh = {in_rem[RemW-3:0], in_x[ProdW-1:ProdW-2]};
        assign trial  = {1'b0, in_root, 2'b01};
        assign ge     = rem_sh >= trial;
        assign adv[k] = !r_v[k] || adv[k+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (adv[k]) begin
                r_v[k] <= in_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv[k]) begin
                r_rem[k]  <= ge ? rem_sh - trial : rem_sh;
                r_root[k] <= {in_root[RootW-2:0], ge};
                r_x[k]    <= {in_x[ProdW-3:0], 2'b00};
                r_side[k] <= in_side;
            end
        end
    end

    assign o_ready = adv[0];
    assign o_valid = r_v[Stages-1];
    assign o_root  = r_root[Stages-1];
    assign o_side  = r_side[Stages-1];

endmodule

// ===== src/trapezoid_velocity_planner_1d.sv =====
// An accepted position passes registers a, b and c, the 32-stage square-root pipeline
// and the output register. Throughput: one position per cycle while no replan runs and
// the output is not stalled. After reset and after each write to registers 0-7 the replan
// sequencer runs up to five serial 64-bit divisions while the input channel is held off.
// Reset is synchronous and active low; it clears the pipeline and loads register defaults.
// Top level of the one-axis trapezoidal velocity planner.
module trapezoid_velocity_planner_1d
    import tvp_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [IdxW-1:0]         i_cfg_index,
    input  logic [PosW-1:0]         i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic signed [PosW-1:0]  i_position,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [PosW-1:0]  o_velocity,
    output logic [1:0]              o_phase
);

    `include "trapezoid_velocity_planner_1d_assert.svh"

    t_plan s_plan;

    tvp_plan u_plan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_plan      (s_plan)
    );

    logic              r_a_v, r_b_v, r_c_v, r_o_v;
    t_side             r_a_side, r_b_side, r_c_side;
    logic [CfgW-1:0]   r_a_k;
    logic [LenW-1:0]   r_a_dist;
    logic [SqW-1:0]    r_a_sq, r_b_sq;
    logic [ProdW-1:0]  r_b_p, r_c_rad;
    logic [PosW-1:0]   r_o_vel;
    logic [1:0]        r_o_phase;

    logic              o_adv, c_adv, b_adv, a_adv;
    logic              sq_ready, sq_valid;
    logic [RootW-1:0]  sq_root;
    t_side             sq_side;

    logic signed [LenW-1:0] dt, ds;
    logic [LenW-1:0]        to_target, traveled;
    t_side                  n_side;
    logic [CfgW-1:0]        n_k;
    logic [LenW-1:0]        n_dist;
    logic [SqW-1:0]         n_sq;

    assign o_adv      = !r_o_v || i_out_ready;
    assign c_adv      = !r_c_v || sq_ready;
    assign b_adv      = !r_b_v || c_adv;
    assign a_adv      = !r_a_v || b_adv;
    assign o_in_ready = a_adv && !s_plan.busy;

    assign dt        = {s_plan.target_pos[PosW-1], s_plan.target_pos} -
                       {i_position[PosW-1], i_position};
    assign ds        = {i_position[PosW-1], i_position} -
                       {s_plan.start_pos[PosW-1], s_plan.start_pos};
    assign to_target = dt[LenW-1] ? LenW'(-dt) : dt;
    assign traveled  = ds[LenW-1] ? LenW'(-ds) : ds;

    always_comb begin
        n_side.direct = 1'b1;
        n_side.dspeed = '0;
        n_side.sign   = s_plan.sign;
        n_side.phase  = PH_DONE;
        n_k           = s_plan.max_acc;
        n_dist        = traveled;
        n_sq          = s_plan.v02;
        if (to_target < {2'b00, s_plan.deadzone}) begin
            n_side.sign = SIGN_ZERO;
        end else if (traveled >= s_plan.len) begin
            n_side.dspeed = s_plan.end_speed;
        end else if ({1'b0, traveled} < s_plan.accel_span) begin
            n_side.direct = 1'b0;
            n_side.phase  = PH_ACCEL;
        end else if ({1'b0, traveled} < ({1'b0, s_plan.len} - s_plan.decel_span)) begin
            n_side.dspeed = s_plan.top;
            n_side.phase  = PH_CRUISE;
        end else begin
            n_side.direct = 1'b0;
            n_side.phase  = PH_DECEL;
            n_k           = s_plan.max_dec;
            n_dist        = s_plan.len - traveled;
            n_sq          = s_plan.vf2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else begin
            if (a_adv) r_a_v <= i_in_valid && o_in_ready;
            if (b_adv) r_b_v <= r_a_v;
            if (c_adv) r_c_v <= r_b_v;
        end
    end

    logic [ProdW:0] rad_sum;
    assign rad_sum = {r_b_p[ProdW-2:0], 2'b00} >> 1;

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_a_side <= n_side;
            r_a_k    <= n_k;
            r_a_dist <= n_dist;
            r_a_sq   <= n_sq;
        end
        if (b_adv) begin
            r_b_side <= r_a_side;
            r_b_p    <= {33'd0, r_a_k} * {31'd0, r_a_dist};
            r_b_sq   <= r_a_sq;
        end
        if (c_adv) begin
            r_c_side <= r_b_side;
            if (r_b_p[ProdW-1])
                r_c_rad <= '1;
            else if (rad_sum + {3'b000, r_b_sq} > {1'b0, {ProdW{1'b1}}})
                r_c_rad <= '1;
            else
                r_c_rad <= ProdW'(rad_sum + {3'b000, r_b_sq});
        end
    end

    tvp_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_c_v),
        .o_ready (sq_ready),
        .i_rad   (r_c_rad),
        .i_side  (r_c_side),
        .o_valid (sq_valid),
        .i_ready (o_adv),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    logic [RootW-1:0] speed, neg_mag;
    logic [PosW-1:0]  n_vel;

    assign speed   = sq_side.direct ? {1'b0, sq_side.dspeed} : sq_root;
    assign neg_mag = (speed > 32'h8000_0000) ? 32'h8000_0000 : speed;

    always_comb begin
        case (sq_side.sign)
            SIGN_POS: n_vel = (speed > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : speed;
            SIGN_NEG: n_vel = 32'd0 - neg_mag;
            default:  n_vel = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (o_adv) begin
            r_o_v <= sq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_o_vel   <= n_vel;
            r_o_phase <= sq_side.phase;
        end
    end

    assign o_out_valid = r_o_v;
    assign o_velocity  = r_o_vel;
    assign o_phase     = r_o_phase;

    `TVP_ASSERT(a_zero_move, o_out_valid && s_plan.sign == SIGN_ZERO |-> o_velocity == '0, "zero-length move gave a nonzero speed")
    `TVP_ASSERT(a_spans, !s_plan.busy |-> s_plan.accel_span <= {1'b0, s_plan.len} && s_plan.decel_span <= {1'b0, s_plan.len}, "span exceeds move length")
    `TVP_ASSERT(a_hold_off, !o_cfg_ready |-> !o_in_ready, "input taken during replan")
    `TVP_ASSERT(a_cruise, o_out_valid && o_phase == PH_CRUISE && s_plan.sign == SIGN_POS |-> o_velocity == {1'b0, s_plan.top}, "cruise speed differs from top speed")

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the one-axis trapezoidal velocity planner.
module tb_top;
    import tvp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 36;
    localparam int REPLAN_WAIT = 400;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_RANDOM = 1800;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic signed [PosW-1:0] velocity;
        logic [1:0]             phase;
    } t_motion;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [IdxW-1:0]        i_cfg_index = '0;
    logic [PosW-1:0]        i_cfg_data = '0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic signed [PosW-1:0] i_position = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic signed [PosW-1:0] o_velocity;
    logic [1:0]             o_phase;

    trapezoid_velocity_planner_1d dut (.*);

    always #5 i_clk = ~i_clk;

    logic [63:0]        acc_lim, dec_lim, vtop, v_start, v_end, dz;
    logic signed [63:0] pos_start, pos_target;
    logic [63:0]        span_len, span_acc, span_dec;
    int                 dir;

    logic signed [PosW-1:0] position_queue[$];
    t_motion                expected_motion[$];
    int                     mismatch_count = 0;
    bit                     holdoff = 1'b0;
    bit                     sender_paused = 1'b0;
    int                     idle_cycles = 0;

    function automatic logic [63:0] floor_sqrt(logic [63:0] x);
        logic [63:0] rem, root, b;
        rem = x;
        root = 0;
        b = 64'd1 << 62;
        while (b > rem) b >>= 2;
        while (b != 0) begin
            if (rem >= root + b) begin
                rem -= root + b;
                root = (root >> 1) + b;
            end else begin
                root >>= 1;
            end
            b >>= 2;
        end
        return root;
    endfunction

    function automatic logic [63:0] ramp_speed(logic [63:0] sq, logic [63:0] k,
                                               logic [63:0] run);
        logic [63:0]  p;
        logic [127:0] wide;
        wide = k * run;
        p = wide[63:0];
        if (wide > 128'hFFFF_FFFF_FFFF_FFFF || p > (64'hFFFF_FFFF_FFFF_FFFF >> 1))
            return floor_sqrt(64'hFFFF_FFFF_FFFF_FFFF);
        p <<= 1;
        if (p > 64'hFFFF_FFFF_FFFF_FFFF - sq) return floor_sqrt(64'hFFFF_FFFF_FFFF_FFFF);
        return floor_sqrt(p + sq);
    endfunction

    function automatic logic [63:0] clamp_to_len(logic signed [63:0] v, logic [63:0] len);
        if (v < 0) return 0;
        if (64'(v) > len) return len;
        return 64'(v);
    endfunction

    task automatic plan_move();
        logic [63:0]        a, d, vt2, v02, vf2, full_a, full_d, s, mag;
        logic signed [63:0] diff, t;
        a = (acc_lim != 0) ? acc_lim : 64'd1;
        d = (dec_lim != 0) ? dec_lim : 64'd1;
        diff = pos_target - pos_start;
        vt2 = vtop * vtop;
        v02 = v_start * v_start;
        vf2 = v_end * v_end;
        span_len = diff < 0 ? 64'(-diff) : 64'(diff);
        dir = diff > 0 ? 1 : (diff < 0 ? -1 : 0);
        full_a = vtop > v_start ? (vt2 - v02) / (2 * a) : 0;
        full_d = vtop > v_end ? (vt2 - vf2) / (2 * d) : 0;
        if (full_a + full_d <= span_len) begin
            span_acc = full_a;
            span_dec = full_d;
        end else begin
            s = a + d;
            mag = vf2 >= v02 ? vf2 - v02 : v02 - vf2;
            t = $signed(mag / (2 * s));
            if (vf2 < v02) t = -t;
            span_acc = clamp_to_len($signed(d * span_len / s) + t, span_len);
            span_dec = clamp_to_len($signed(a * span_len / s) - t, span_len);
        end
    endtask

    task automatic store_register(logic [IdxW-1:0] idx, logic [PosW-1:0] val);
        case (idx)
            REG_MAX_ACC:  acc_lim = val[30:0];
            REG_MAX_DEC:  dec_lim = val[30:0];
            REG_TOP:      vtop = val[30:0];
            REG_START_V:  v_start = val[30:0];
            REG_END_V:    v_end = val[30:0];
            REG_START_P:  pos_start = $signed(val);
            REG_TARGET_P: pos_target = $signed(val);
            REG_DEADZONE: dz = val[30:0];
            default:      return;
        endcase
        plan_move();
    endtask

    function automatic t_motion target_motion(logic signed [PosW-1:0] pos);
        t_motion            r;
        logic signed [63:0] dt, ds;
        logic [63:0]        to_go, done, spd, m;
        dt = pos_target - 64'(pos);
        ds = 64'(pos) - pos_start;
        to_go = dt < 0 ? 64'(-dt) : 64'(dt);
        done = ds < 0 ? 64'(-ds) : 64'(ds);
        if (to_go < dz) begin
            r.velocity = '0;
            r.phase = PH_DONE;
            return r;
        end
        if (done >= span_len) begin
            spd = v_end;
            r.phase = PH_DONE;
        end else if (done < span_acc) begin
            spd = ramp_speed(v_start * v_start, acc_lim, done);
            r.phase = PH_ACCEL;
        end else if ($signed(done) < $signed(span_len) - $signed(span_dec)) begin
            spd = vtop;
            r.phase = PH_CRUISE;
        end else begin
            spd = ramp_speed(v_end * v_end, dec_lim, span_len - done);
            r.phase = PH_DECEL;
        end
        if (dir > 0) begin
            r.velocity = spd > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : spd[31:0];
        end else if (dir < 0) begin
            m = spd > 64'h8000_0000 ? 64'h8000_0000 : spd;
            r.velocity = 32'(64'd0 - m);
        end else begin
            r.velocity = '0;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        mismatch_count++;
    endtask

    // Sender: bursts of random length separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            expected_motion.push_back(target_motion(i_position));
            void'(position_queue.pop_front());
        end
        if (i_in_valid && !o_in_ready) begin
            // Hold the offered transaction until it is taken.
        end else if (!i_rst_n || sender_paused || position_queue.size() == 0) begin
            i_in_valid <= 1'b0;
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            i_in_valid <= 1'b0;
        end else begin
            i_in_valid <= 1'b1;
            i_position <= position_queue[0];
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 30);
                gap_left <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 6) : 0;
            end else begin
                burst_left <= burst_left - 1;
            end
        end
    end

    // Receiver: its own stall pattern, plus a long hold-off on request.
    int stall_mode = 0;
    int hold_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 3);
            if (holdoff && hold_left == 0) hold_left <= HOLD_CYCLES;
            else if (hold_left > 0) hold_left <= hold_left - 1;
            case (stall_mode)
                0: i_out_ready <= !holdoff && hold_left == 0;
                1: i_out_ready <= !holdoff && hold_left == 0 && ($urandom_range(0, 3) != 0);
                2: i_out_ready <= !holdoff && hold_left == 0 && $urandom_range(0, 1);
                default: i_out_ready <= !holdoff && hold_left == 0
                                        && ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // Monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_motion.size() == 0) begin
                report_mismatch("unexpected result", o_velocity, 0);
            end else begin
                if (o_velocity !== expected_motion[0].velocity)
                    report_mismatch("velocity", o_velocity, expected_motion[0].velocity);
                if (o_phase !== expected_motion[0].phase)
                    report_mismatch("phase", o_phase, expected_motion[0].phase);
                void'(expected_motion.pop_front());
            end
        end
    end

    // Watchdog on cycles without any accepted transaction.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic drain();
        wait (position_queue.size() == 0 && !i_in_valid);
        wait (expected_motion.size() == 0);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_register(logic [IdxW-1:0] idx, logic [PosW-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        store_register(idx, val);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [PosW-1:0] rand_cfg(bit wide_range);
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'd1;
            2: return $urandom_range(0, 64);
            default: return wide_range ? {1'b0, 31'($urandom)} : $urandom_range(1, 1 << 20);
        endcase
    endfunction

    task automatic random_move();
        logic signed [PosW-1:0] s, t;
        s = $urandom;
        t = s + $signed($urandom_range(0, 1 << 26)) - (1 << 25);
        if ($urandom_range(0, 9) == 0) t = $urandom;
        if ($urandom_range(0, 19) == 0) t = s;
        write_register(REG_START_P, s);
        write_register(REG_TARGET_P, t);
        write_register(REG_MAX_ACC, ($urandom_range(0, 9) == 0) ? rand_cfg(1)
                                    : $urandom_range(1, 1 << 18));
        write_register(REG_MAX_DEC, ($urandom_range(0, 9) == 0) ? rand_cfg(1)
                                    : $urandom_range(1, 1 << 18));
        write_register(REG_TOP, ($urandom_range(0, 9) == 0) ? rand_cfg(1)
                                : $urandom_range(0, 1 << 22));
        write_register(REG_START_V, ($urandom_range(0, 3) == 0) ? rand_cfg(1)
                                    : $urandom_range(0, 1 << 20));
        write_register(REG_END_V, ($urandom_range(0, 3) == 0) ? rand_cfg(1)
                                  : $urandom_range(0, 1 << 20));
        write_register(REG_DEADZONE, ($urandom_range(0, 3) == 0) ? 32'd0
                                     : $urandom_range(0, 1 << 14));
        if ($urandom_range(0, 4) == 0) write_register(4'd8 + 4'($urandom_range(0, 7)), $urandom);
    endtask

    task automatic queue_positions(int n);
        logic signed [63:0] lo, span;
        logic signed [PosW-1:0] p;
        lo = pos_start;
        span = pos_target - pos_start;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) == 0)
                p = $urandom;
            else
                p = 32'(lo + (span * $signed(64'($urandom_range(0, 1100)))) / 1000
                        + $signed(64'($urandom_range(0, 64))) - 32);
            position_queue.push_back(p);
        end
    endtask

    initial begin
        acc_lim = 65536; dec_lim = 65536; vtop = 65536; v_start = 0; v_end = 0;
        pos_start = 0; pos_target = 0; dz = 0;
        plan_move();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset plan, then extremes.
        position_queue.push_back(32'sh0);
        position_queue.push_back(32'sh7FFF_FFFF);
        position_queue.push_back(-32'sh8000_0000);
        drain();
        write_register(REG_START_P, -32'sh8000_0000);
        write_register(REG_TARGET_P, 32'sh7FFF_FFFF);
        write_register(REG_MAX_ACC, 32'h7FFF_FFFF);
        write_register(REG_MAX_DEC, 32'h7FFF_FFFF);
        write_register(REG_TOP, 32'h7FFF_FFFF);
        write_register(REG_START_V, 32'h7FFF_FFFF);
        write_register(REG_END_V, 32'h7FFF_FFFF);
        write_register(REG_DEADZONE, 32'h7FFF_FFFF);
        position_queue.push_back(32'sh7FFF_FFFF);
        position_queue.push_back(-32'sh8000_0000);
        position_queue.push_back(32'sh0);
        position_queue.push_back(32'sh5555_5555);
        drain();
        write_register(REG_DEADZONE, 32'd0);
        write_register(REG_START_V, 32'd0);
        write_register(REG_END_V, 32'd0);
        write_register(REG_MAX_ACC, 32'd1);
        write_register(REG_MAX_DEC, 32'd0);
        position_queue.push_back(-32'sh8000_0000);
        position_queue.push_back(32'sh0000_0001);
        position_queue.push_back(32'sh2AAA_AAAA);
        position_queue.push_back(32'sh7FFF_FFFE);
        position_queue.push_back(32'sh7FFF_FFFF);
        drain();
        write_register(REG_START_P, 32'sh7FFF_FFFF);
        write_register(REG_TARGET_P, -32'sh8000_0000);
        write_register(REG_TOP, 32'd0);
        position_queue.push_back(32'sh7FFF_FFFF);
        position_queue.push_back(32'sh0);
        position_queue.push_back(-32'sh7FFF_FFFF);
        position_queue.push_back(-32'sh8000_0000);
        drain();

        // Random moves, including a long receiver hold-off while positions are queued and a sender pause.
        for (int m = 0; m < 60; m++) begin
            random_move();
            queue_positions(N_RANDOM / 60);
            if (m == 5) begin
                holdoff = 1'b1;
                wait (hold_left != 0);
                holdoff = 1'b0;
                wait (hold_left == 0);
            end
            if (m == 10) begin
                sender_paused = 1'b1;
                wait (expected_motion.size() == 0 && !i_in_valid);
                repeat (20) @(posedge i_clk);
                sender_paused = 1'b0;
            end
            drain();
        end
        repeat (REPLAN_WAIT) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
